>>> rtl/dqks_pkg.sv
// ----------------------------------------------------------------------------
// dqks_pkg
// Shared types and constants for the deque with key search: command and
// status codes, the input and result beat layouts, and the stored entry.
// ----------------------------------------------------------------------------
package dqks_pkg;

  localparam int DQKS_DEPTH = 16;
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int FILL_W     = 5;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_CLEAR      = 3'd4,
    CMD_READ_FRONT = 3'd5,
    CMD_READ_BACK  = 3'd6,
    CMD_FIND       = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t             command;
    logic [KEY_W-1:0] name_key;
    logic [VAL_W-1:0] url_word;
  } in_beat_t;

  typedef struct packed {
    status_t           status;
    logic [KEY_W-1:0]  found_name;
    logic [VAL_W-1:0]  found_url;
    logic [FILL_W-1:0] fill_count;
  } out_beat_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } dqks_entry_t;

endpackage

>>> rtl/deque_with_key_search.sv
// ----------------------------------------------------------------------------
// deque_with_key_search
// Bounded double-ended queue of key/value entries held in a ring in one
// synchronous memory, with push/pop at both ends, clear, end reads and a
// find that walks from the back toward the front.
// ----------------------------------------------------------------------------
// Timing: push, pop and clear give their result in the cycle after the accepted
//   beat; read front/back goes through the memory read register and S_READ;
//   find walks in S_SCAN from the back toward the front, one memory read per cycle.
// Throughput: push/pop/clear every cycle; busy holds off start during reads
//   and the find walk. Results strobe for one cycle, the receiver cannot stall.
// Reset: rst_n synchronous, active low; deque empty, front slot 0. Entry
//   storage is not cleared, only pushed entries are ever read.
module deque_with_key_search
  import dqks_pkg::*;
#(
  parameter int DEPTH = DQKS_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_beat,
  output logic      out_strobe,
  output out_beat_t out_beat
);

  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = SLOT_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN
  } state_t;

  // ring position -> slot; front + pos stays below 2*DEPTH
  function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] front,
                                                input logic [CNT_W-1:0]  pos);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(front) + SUM_W'(pos);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[SLOT_W-1:0];
  endfunction

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SLOT_W-1:0] scan_pos_r, scan_pos_nxt;   // position of data arriving now
  logic [KEY_W-1:0]  key_r, key_nxt;             // key under search
  logic              out_strobe_r, out_strobe_nxt;
  out_beat_t         out_beat_r, out_beat_nxt;

  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  dqks_entry_t       wr_entry;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  dqks_entry_t       rd_entry;

  logic              accept;
  logic              is_empty;
  logic              is_full;

  assign accept   = start && (state_r == S_IDLE);
  assign is_empty = (cnt_r == '0);
  assign is_full  = (cnt_r == CNT_W'(DEPTH));

  dqks_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    cnt_nxt        = cnt_r;
    scan_pos_nxt   = scan_pos_r;
    key_nxt        = key_r;
    out_strobe_nxt = 1'b0;
    out_beat_nxt   = out_beat_r;
    wr_en          = 1'b0;
    wr_addr        = front_r;
    wr_entry       = '{key: in_beat.name_key, val: in_beat.url_word};
    rd_en          = 1'b0;
    rd_addr        = front_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          out_beat_nxt.status     = ST_OK;
          out_beat_nxt.found_name = '0;
          out_beat_nxt.found_url  = '0;
          unique case (in_beat.command) inside
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              out_strobe_nxt = 1'b1;
              if (is_full) begin
                out_beat_nxt.status = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
                if (in_beat.command == CMD_PUSH_FRONT) begin
                  front_nxt = (front_r == '0) ? SLOT_W'(DEPTH - 1) : front_r - 1'b1;
                  wr_addr   = front_nxt;
                end else begin
                  wr_addr = slot_of(front_r, cnt_r);
                end
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              out_strobe_nxt = 1'b1;
              if (is_empty) begin
                out_beat_nxt.status = ST_EMPTY;
              end else begin
                cnt_nxt = cnt_r - 1'b1;
                if (in_beat.command == CMD_POP_FRONT) begin
                  front_nxt = (front_r == SLOT_W'(DEPTH - 1)) ? '0 : front_r + 1'b1;
                end
              end
            end
            CMD_CLEAR: begin
              out_strobe_nxt = 1'b1;
              cnt_nxt        = '0;
              front_nxt      = '0;
            end
            CMD_READ_FRONT, CMD_READ_BACK: begin
              if (is_empty) begin
                out_strobe_nxt      = 1'b1;
                out_beat_nxt.status = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = (in_beat.command == CMD_READ_FRONT) ? front_r
                                                                : slot_of(front_r, cnt_r - 1'b1);
                state_nxt = S_READ;
              end
            end
            CMD_FIND: begin
              if (is_empty) begin
                out_strobe_nxt      = 1'b1;
                out_beat_nxt.status = ST_MISS;
              end else begin
                // first read at the back, then walk toward the front
                rd_en        = 1'b1;
                rd_addr      = slot_of(front_r, cnt_r - 1'b1);
                scan_pos_nxt = SLOT_W'(cnt_r - 1'b1);
                key_nxt      = in_beat.name_key;
                state_nxt    = S_SCAN;
              end
            end
            default: begin
              out_strobe_nxt = 1'b0;
            end
          endcase
        end
      end
      S_READ: begin
        out_strobe_nxt          = 1'b1;
        out_beat_nxt.status     = ST_OK;
        out_beat_nxt.found_name = rd_entry.key;
        out_beat_nxt.found_url  = rd_entry.val;
        state_nxt               = S_IDLE;
      end
      S_SCAN: begin
        if (rd_entry.key == key_r) begin
          out_strobe_nxt          = 1'b1;
          out_beat_nxt.status     = ST_OK;
          out_beat_nxt.found_name = rd_entry.key;
          out_beat_nxt.found_url  = rd_entry.val;
          state_nxt               = S_IDLE;
        end else if (scan_pos_r == '0) begin
          out_strobe_nxt          = 1'b1;
          out_beat_nxt.status     = ST_MISS;
          out_beat_nxt.found_name = '0;
          out_beat_nxt.found_url  = '0;
          state_nxt               = S_IDLE;
        end else begin
          // prefetch the next entry toward the front
          rd_en        = 1'b1;
          rd_addr      = slot_of(front_r, CNT_W'(scan_pos_r - 1'b1));
          scan_pos_nxt = scan_pos_r - 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_beat_nxt.fill_count = FILL_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      front_r      <= '0;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      front_r      <= front_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
      out_beat_r   <= out_beat_nxt;
      scan_pos_r   <= scan_pos_nxt;
      key_r        <= key_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_beat   = out_beat_r;

`ifndef SYNTH
  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_front_bound : assert property (@(posedge clk) disable iff (!rst_n)
    SUM_W'(front_r) < SUM_W'(DEPTH))
    else $error("front slot out of range");

  a_scan_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (CNT_W'(scan_pos_r) < cnt_r))
    else $error("find walk beyond held entries");

  a_full_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_beat_r.status == ST_FULL) |-> (cnt_r == CNT_W'(DEPTH)))
    else $error("full status with room left");

  a_clear_effect : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_beat.command == CMD_CLEAR)
      |=> (out_strobe_r && cnt_r == '0 && front_r == '0))
    else $error("clear did not empty the deque");
`endif

endmodule

>>> rtl/dqks_store.sv
// ----------------------------------------------------------------------------
// dqks_store
// Entry storage: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dqks_store
  import dqks_pkg::*;
#(
  parameter  int DEPTH  = DQKS_DEPTH,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  dqks_entry_t       wr_entry,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output dqks_entry_t       rd_entry
);

  dqks_entry_t mem_r [DEPTH];
  dqks_entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry_r <= mem_r[rd_addr];
    end
  end

  assign rd_entry = rd_entry_r;

endmodule
